// ===== rtl/lpma_pkg.sv =====
// lpma_pkg: shared widths, register codes, microcode words and the control program
// for the level percent moving average core
// no dependencies
`default_nettype none

package lpma_pkg;

    // filter window, in samples (1 to 64)
    localparam int WINDOW = 10;

    // field widths
    localparam int MV_W  = 12;
    localparam int PCT_W = 15;

    localparam int PCT_FULL = 25600;   // 100 percent, 8 fraction bits

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(PCT_FULL * WINDOW + 1);

    // shared divider: quotients never exceed full scale
    localparam int PROD_W = MV_W + PCT_W;
    localparam int NUM_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam int QUO_W  = PCT_W;
    localparam int DVS_W  = (MV_W > FILL_W) ? MV_W : FILL_W;
    localparam int CNT_W  = $clog2(QUO_W + 1);

    // stream word widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LEVEL = 2'd1;

    localparam logic [MV_W-1:0] FULL_LEVEL_RST  = 12'd1800;
    localparam logic [MV_W-1:0] EMPTY_LEVEL_RST = 12'd3000;

    // datapath operations
    typedef enum logic [3:0] {
        OP_WAIT,
        OP_CMP,
        OP_MUL,
        OP_DLOAD_PCT,
        OP_DSTEP,
        OP_TAKE_PCT,
        OP_UPDATE,
        OP_DLOAD_AVG,
        OP_EMIT
    } t_op;

    // jump conditions, taken when true, otherwise fall through
    typedef enum logic [2:0] {
        J_NEXT,
        J_IF_NO_IN,
        J_IF_NO_DIV,
        J_IF_DIV_MORE,
        J_IF_OUT_BUSY
    } t_jump;

    localparam int STEP_W   = 4;
    localparam int PROG_LEN = 10;

    typedef logic [STEP_W-1:0] t_step;

    // program addresses
    localparam t_step ST_WAIT     = 4'd0;
    localparam t_step ST_CMP      = 4'd1;
    localparam t_step ST_MUL      = 4'd2;
    localparam t_step ST_DLD_PCT  = 4'd3;
    localparam t_step ST_DIV_PCT  = 4'd4;
    localparam t_step ST_TAKE_PCT = 4'd5;
    localparam t_step ST_UPDATE   = 4'd6;
    localparam t_step ST_DLD_AVG  = 4'd7;
    localparam t_step ST_DIV_AVG  = 4'd8;
    localparam t_step ST_EMIT     = 4'd9;

    typedef struct packed {
        t_op   op;
        t_jump jmp;
        t_step target;
    } t_uword;

    // status fed back to the sequencer for its jumps
    typedef struct packed {
        logic in_valid;
        logic no_div;
        logic div_more;
        logic out_busy;
    } t_seq_stat;

    // divider controls
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    // control store
    function automatic t_uword ucode(input t_step addr);
        t_uword w;
        w = '{op: OP_WAIT, jmp: J_NEXT, target: ST_WAIT};
        case (addr)
            ST_WAIT:     w = '{op: OP_WAIT,      jmp: J_IF_NO_IN,    target: ST_WAIT};
            ST_CMP:      w = '{op: OP_CMP,       jmp: J_IF_NO_DIV,   target: ST_UPDATE};
            ST_MUL:      w = '{op: OP_MUL,       jmp: J_NEXT,        target: ST_WAIT};
            ST_DLD_PCT:  w = '{op: OP_DLOAD_PCT, jmp: J_NEXT,        target: ST_WAIT};
            ST_DIV_PCT:  w = '{op: OP_DSTEP,     jmp: J_IF_DIV_MORE, target: ST_DIV_PCT};
            ST_TAKE_PCT: w = '{op: OP_TAKE_PCT,  jmp: J_NEXT,        target: ST_WAIT};
            ST_UPDATE:   w = '{op: OP_UPDATE,    jmp: J_NEXT,        target: ST_WAIT};
            ST_DLD_AVG:  w = '{op: OP_DLOAD_AVG, jmp: J_NEXT,        target: ST_WAIT};
            ST_DIV_AVG:  w = '{op: OP_DSTEP,     jmp: J_IF_DIV_MORE, target: ST_DIV_AVG};
            ST_EMIT:     w = '{op: OP_EMIT,      jmp: J_IF_OUT_BUSY, target: ST_EMIT};
            default:     w = '{op: OP_WAIT,      jmp: J_NEXT,        target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lpma_seq.sv =====
// lpma_seq: step counter, control store lookup and conditional jumps
// depends on lpma_pkg
`default_nettype none

module lpma_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lpma_pkg::t_seq_stat i_stat,
    output lpma_pkg::t_uword        o_uword
);
    import lpma_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_step  w_fall;
    t_uword w_uword;
    logic   w_take;

    assign w_uword = ucode(r_step);
    assign o_uword = w_uword;

    // fall-through wraps from the last step back to the wait step
    assign w_fall = (r_step == STEP_W'(PROG_LEN - 1)) ? ST_WAIT : r_step + 1'b1;

    always_comb begin
        case (w_uword.jmp)
            J_NEXT:        w_take = 1'b0;
            J_IF_NO_IN:    w_take = !i_stat.in_valid;
            J_IF_NO_DIV:   w_take = i_stat.no_div;
            J_IF_DIV_MORE: w_take = i_stat.div_more;
            J_IF_OUT_BUSY: w_take = i_stat.out_busy;
            default:       w_take = 1'b0;
        endcase
        n_step = w_take ? w_uword.target : w_fall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lpma_div.sv =====
// lpma_div: restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits
// depends on lpma_pkg
`default_nettype none

module lpma_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lpma_pkg::t_div_ctl          i_ctl,
    input  wire logic [lpma_pkg::NUM_W-1:0]  i_num,
    input  wire logic [lpma_pkg::DVS_W-1:0]  i_den,
    output logic      [lpma_pkg::QUO_W-1:0]  o_quo,
    output logic                             o_more
);
    import lpma_pkg::*;

    logic [DVS_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [DVS_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W:0]   w_trial;
    logic             w_fit;

    // numerator's upper part is below the divisor, so it seeds the remainder
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= DVS_W'(i_num >> QUO_W);
            r_quo <= i_num[QUO_W-1:0];
            r_den <= i_den;
        end else if (i_ctl.step) begin
            r_rem <= w_fit ? DVS_W'(w_trial - {1'b0, r_den}) : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= CNT_W'(QUO_W);
        end else if (i_ctl.step && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quo  = r_quo;
    // more iterations remain after the current one
    assign o_more = (r_cnt > CNT_W'(1));

endmodule

`default_nettype wire

// ===== rtl/level_percent_moving_average_core.sv =====
// level_percent_moving_average_core: sensor voltage to level percent with moving average
// depends on lpma_pkg, lpma_seq, lpma_div
//
//   channel   dir  handshake                       word
//   s_axis    in   i_s_axis_tvalid/o_s_axis_tready  sample_mv
//   m_axis    out  o_m_axis_tvalid/i_m_axis_tready  sample_pct, average_pct
//   cfg       in   i_cfg_valid/o_cfg_ready          index, data (always ready)
//
// an interpolated sample uses the shared divider twice, a clamped one (full or empty) only once,
// for the average; the divider gives one quotient bit per cycle, a 15-bit quotient per division
// synchronous active-low reset clears the sequencer, divider count, ring pointer, fill count,
// sum and output valid, and restores the default thresholds; history needs no clearing
// the output register lets the next word be taken while a result waits; the
// sequencer holds at its emit step only when the previous result is still unread
`default_nettype none

module level_percent_moving_average_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // sample word: [11:0] sample_mv, [15:12] zero
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [lpma_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // result word: [14:0] sample_pct, [29:15] average_pct, [31:30] zero
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic      [lpma_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // register writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lpma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lpma_pkg::MV_W-1:0]     i_cfg_data
);
    import lpma_pkg::*;

    // configuration thresholds
    logic [MV_W-1:0] r_full_mv;
    logic [MV_W-1:0] r_empty_mv;

    // per-item working registers
    logic [MV_W-1:0]  r_v;
    logic [MV_W-1:0]  r_diff;
    logic [DVS_W-1:0] r_span;
    logic [NUM_W-1:0] r_num;
    logic [PCT_W-1:0] r_pct;

    // filter state
    logic [PCT_W-1:0]  r_hist [WINDOW];
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [FILL_W-1:0] r_filled;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic              w_win_full;

    // output register
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    t_uword           w_uword;
    t_seq_stat        w_stat;
    t_div_ctl         w_div_ctl;
    logic [NUM_W-1:0] w_div_num;
    logic [DVS_W-1:0] w_div_den;
    logic [QUO_W-1:0] w_quo;
    logic             w_div_more;

    logic              w_s_accept;
    logic              w_le_full;
    logic              w_ge_empty;
    logic              w_out_busy;
    logic [PROD_W-1:0] w_prod;

    // ---------------------------------------------------------------- handshakes
    assign o_s_axis_tready = (w_uword.op == OP_WAIT);
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign w_out_busy      = r_m_valid && !i_m_axis_tready;

    // ---------------------------------------------------------------- sequencer
    assign w_le_full  = (r_v <= r_full_mv);
    assign w_ge_empty = (r_v >= r_empty_mv);

    assign w_stat.in_valid = i_s_axis_tvalid;
    assign w_stat.no_div   = w_le_full || w_ge_empty;
    assign w_stat.div_more = w_div_more;
    assign w_stat.out_busy = w_out_busy;

    lpma_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uword (w_uword)
    );

    // ---------------------------------------------------------------- divider
    // two users: the interpolation and the mean over the filled entries
    assign w_div_ctl.load = (w_uword.op == OP_DLOAD_PCT) || (w_uword.op == OP_DLOAD_AVG);
    assign w_div_ctl.step = (w_uword.op == OP_DSTEP);
    assign w_div_num = (w_uword.op == OP_DLOAD_AVG) ? NUM_W'(r_sum) : r_num;
    assign w_div_den = (w_uword.op == OP_DLOAD_AVG) ? DVS_W'(r_filled) : r_span;

    lpma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quo   (w_quo),
        .o_more  (w_div_more)
    );

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_mv  <= FULL_LEVEL_RST;
            r_empty_mv <= EMPTY_LEVEL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FULL_LEVEL:  r_full_mv  <= i_cfg_data;
                REG_EMPTY_LEVEL: r_empty_mv <= i_cfg_data;
                default: ;  // unknown register, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- level path
    assign w_prod = PROD_W'(r_diff) * PROD_W'(PCT_FULL);

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_v <= i_s_axis_tdata[MV_W-1:0];
        end
        case (w_uword.op)
            OP_CMP: begin
                // full test wins when the thresholds cross
                r_pct  <= w_le_full ? PCT_W'(PCT_FULL) : '0;
                r_diff <= r_empty_mv - r_v;
                r_span <= DVS_W'(r_empty_mv - r_full_mv);
            end
            OP_MUL: begin
                r_num <= NUM_W'(w_prod);
            end
            OP_TAKE_PCT: begin
                r_pct <= w_quo;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- filter
    assign w_win_full = (r_filled == FILL_W'(WINDOW));
    assign n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    // oldest entry leaves only once the ring is full, so unwritten slots are never summed
    assign n_sum  = r_sum + SUM_W'(r_pct) - (w_win_full ? SUM_W'(r_hist[r_slot]) : '0);

    always_ff @(posedge i_clk) begin
        if (w_uword.op == OP_UPDATE) begin
            r_hist[r_slot] <= r_pct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_filled <= '0;
            r_sum    <= '0;
        end else if (w_uword.op == OP_UPDATE) begin
            r_slot <= n_slot;
            r_sum  <= n_sum;
            if (!w_win_full) begin
                r_filled <= r_filled + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_uword.op == OP_EMIT && !w_out_busy) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uword.op == OP_EMIT && !w_out_busy) begin
            r_m_data <= M_DATA_W'({w_quo, r_pct});
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // ---------------------------------------------------------------- checks
    // an accepted word always starts the compare step
    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> (w_uword.op == OP_CMP))
        else $error("accepted sample did not start compare");

    // fill count saturates at the window length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FILL_W'(WINDOW))
        else $error("fill count beyond window");

    // an emit with a free output register presents a result next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uword.op == OP_EMIT && !w_out_busy) |=> r_m_valid)
        else $error("emit lost");

    // no new sample is taken while the divider still iterates
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctl.step |-> !o_s_axis_tready)
        else $error("input ready during division");

endmodule

`default_nettype wire
